[rtl/core/elias_gamma_delta_codec_unit_assert.svh]
// Assertion macros for the Elias gamma/delta codec checker.
// Standalone header; the users supply clock, reset and expressions.
`ifndef ELIAS_GAMMA_DELTA_CODEC_UNIT_ASSERT_SVH
`define ELIAS_GAMMA_DELTA_CODEC_UNIT_ASSERT_SVH

// same-cycle implication
`define EGDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("egdc assertion failed");

// next-cycle implication
`define EGDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("egdc assertion failed");

`endif

[rtl/core/egdc_pkg.sv]
// Shared constants and types of the Elias gamma/delta codec.
// No dependencies.
package egdc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int CODE_W     = 64;
	localparam int LEN_W      = 6;
	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int BYTE_BITS  = 8;
	localparam int LEAD_W     = $clog2(VALUE_BITS);

	localparam logic [FUNC_W-1:0] KIND_GAMMA = 2'd0;
	localparam logic [FUNC_W-1:0] KIND_DELTA = 2'd1;
	localparam logic [FUNC_W-1:0] KIND_BYTE  = 2'd2;
	localparam logic [FUNC_W-1:0] KIND_BAD   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_ENCODED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DECODED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0]     code_bits;
		logic [LEN_W-1:0]      code_length;
		logic [VALUE_BITS-1:0] decoded_value;
		logic [STATUS_W-1:0]   status;
	} result_t;

	typedef struct packed {
		logic [1:0]            phase;
		logic [LEN_W-1:0]      prefix_count;
		logic [VALUE_BITS-1:0] acc;
		logic [LEN_W-1:0]      bits_left;
		logic [FUNC_W-1:0]     kind;
		logic                  delta_stage;
	} dec_state_t;

endpackage

[rtl/core/egdc_stream_if.sv]
// Valid/ready channel interfaces for codec input items and results.
// Depends on egdc_pkg.
interface egdc_in_if;
	logic                            valid;
	logic                            ready;
	logic [egdc_pkg::FUNC_W-1:0]     func;
	logic [egdc_pkg::VALUE_BITS-1:0] value;
	logic                            coded_bit;
	logic                            stream_end;

	modport source (output valid, func, value, coded_bit, stream_end, input ready);
	modport sink (input valid, func, value, coded_bit, stream_end, output ready);
endinterface

interface egdc_out_if;
	logic                            valid;
	logic                            ready;
	logic [egdc_pkg::CODE_W-1:0]     code_bits;
	logic [egdc_pkg::LEN_W-1:0]      code_length;
	logic [egdc_pkg::VALUE_BITS-1:0] decoded_value;
	logic [egdc_pkg::STATUS_W-1:0]   status;

	modport source (output valid, code_bits, code_length, decoded_value, status, input ready);
	modport sink (input valid, code_bits, code_length, decoded_value, status, output ready);
endinterface

[rtl/core/egdc_encoder.sv]
// Combinational encoder: value to packed gamma, delta or byte code word.
// Depends on egdc_pkg.
module egdc_encoder (
	input  logic [egdc_pkg::FUNC_W-1:0]     func,
	input  logic [egdc_pkg::VALUE_BITS-1:0] value,
	output egdc_pkg::result_t               result
);

	logic [egdc_pkg::LEAD_W-1:0] n;
	logic [egdc_pkg::LEN_W-1:0]  m;
	logic [2:0]                  k;
	logic [egdc_pkg::CODE_W-1:0] low;
	logic [egdc_pkg::CODE_W-1:0] gamma_bits;
	logic [8:0]                  g;
	logic [3:0]                  glen;

	always_comb begin
		n = '0;
		for (int i = 0; i < egdc_pkg::VALUE_BITS; i++) begin
			if (value[i]) n = egdc_pkg::LEAD_W'(i);
		end
	end

	assign m = egdc_pkg::LEN_W'(n) + 6'd1;

	always_comb begin
		k = '0;
		for (int i = 0; i < egdc_pkg::LEN_W; i++) begin
			if (m[i]) k = 3'(i);
		end
	end

	// low bits of value below its leading one
	assign low = egdc_pkg::CODE_W'(value) ^ (64'd1 << n);
	assign gamma_bits = (((64'd1 << n) - 64'd1) << m) | low;
	assign g = (((9'd1 << k) - 9'd1) << (k + 3'd1)) | (9'(m) ^ (9'd1 << k));
	assign glen = {k, 1'b1};

	always_comb begin
		result = '0;
		case (func)
			egdc_pkg::KIND_BYTE: begin
				result.code_bits   = egdc_pkg::CODE_W'(value[egdc_pkg::BYTE_BITS-1:0]);
				result.code_length = egdc_pkg::LEN_W'(egdc_pkg::BYTE_BITS);
				result.status      = egdc_pkg::ST_ENCODED;
			end
			egdc_pkg::KIND_GAMMA: begin
				if (value == '0) begin
					result.status = egdc_pkg::ST_INVALID;
				end else begin
					result.code_bits   = gamma_bits;
					result.code_length = egdc_pkg::LEN_W'({n, 1'b1});
					result.status      = egdc_pkg::ST_ENCODED;
				end
			end
			egdc_pkg::KIND_DELTA: begin
				if (value == '0) begin
					result.status = egdc_pkg::ST_INVALID;
				end else begin
					result.code_bits   = (egdc_pkg::CODE_W'(g) << n) | low;
					result.code_length = egdc_pkg::LEN_W'(glen) + egdc_pkg::LEN_W'(n);
					result.status      = egdc_pkg::ST_ENCODED;
				end
			end
			default: begin
				result.status = egdc_pkg::ST_INVALID;
			end
		endcase
	end

endmodule

[rtl/core/elias_gamma_delta_codec_unit.sv]
// Elias gamma/delta/byte codec: input register, one pass of logic, result register.
// Throughput one item per cycle while the result channel is not stalled.
// Decode items that finish no code give no result; decoder state updates as the
// input register drains into the result stage.
// Reset: direction encode, decoder awaiting first bit, both stages empty.
// Depends on egdc_pkg, egdc_stream_if, egdc_encoder.
module elias_gamma_delta_codec_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	egdc_in_if.sink     in_ch,
	egdc_out_if.source  out_ch
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_PREFIX = 2'd1;
	localparam logic [1:0] PH_BINARY = 2'd2;

	logic                            dir_q;
	logic                            s1_v;
	logic [egdc_pkg::FUNC_W-1:0]     func_s1;
	logic [egdc_pkg::VALUE_BITS-1:0] value_s1;
	logic                            bit_s1;
	logic                            end_s1;
	logic                            out_v_s2;
	egdc_pkg::result_t               res_s2;
	egdc_pkg::dec_state_t            dec_q;
	egdc_pkg::dec_state_t            dec_d;
	egdc_pkg::result_t               enc_res;
	egdc_pkg::result_t               dec_res;
	logic                            dec_emit;
	logic                            adv;
	logic                            s1_fire;
	logic                            in_fire;
	logic                            emit;

	egdc_encoder u_enc (
		.func   (func_s1),
		.value  (value_s1),
		.result (enc_res)
	);

	always_comb begin
		logic                            done;
		logic                            fin;
		logic                            fail;
		logic                            ok;
		logic [egdc_pkg::STATUS_W-1:0]   fail_st;
		logic [egdc_pkg::VALUE_BITS-1:0] ok_val;
		dec_d   = dec_q;
		dec_res = '0;
		dec_emit = 1'b0;
		done    = 1'b0;
		fin     = 1'b0;
		fail    = 1'b0;
		ok      = 1'b0;
		fail_st = egdc_pkg::ST_INVALID;
		ok_val  = '0;
		if (dec_d.phase == PH_IDLE) begin
			dec_d      = '0;
			dec_d.kind = func_s1;
			if (func_s1 == egdc_pkg::KIND_BAD) begin
				fail = 1'b1;
				done = 1'b1;
			end else if (func_s1 == egdc_pkg::KIND_BYTE) begin
				dec_d.phase     = PH_BINARY;
				dec_d.bits_left = egdc_pkg::LEN_W'(egdc_pkg::BYTE_BITS);
			end else begin
				dec_d.phase = PH_PREFIX;
			end
		end
		if (!done) begin
			if (dec_d.phase == PH_PREFIX) begin
				if (bit_s1) begin
					dec_d.prefix_count = dec_d.prefix_count + 6'd1;
					if (dec_d.prefix_count >= egdc_pkg::LEN_W'(egdc_pkg::VALUE_BITS)) begin
						fail = 1'b1;
					end else if (end_s1) begin
						fail    = 1'b1;
						fail_st = egdc_pkg::ST_TRUNC;
					end
				end else begin
					dec_d.acc = egdc_pkg::VALUE_BITS'(1);
					if (dec_d.prefix_count == '0) begin
						fin = 1'b1;
					end else begin
						dec_d.phase        = PH_BINARY;
						dec_d.bits_left    = dec_d.prefix_count;
						dec_d.prefix_count = '0;
						if (end_s1) begin
							fail    = 1'b1;
							fail_st = egdc_pkg::ST_TRUNC;
						end
					end
				end
			end else begin
				dec_d.acc = {dec_d.acc[egdc_pkg::VALUE_BITS-2:0], bit_s1};
				if (dec_d.bits_left != '0) dec_d.bits_left = dec_d.bits_left - 6'd1;
				if (dec_d.bits_left == '0) begin
					if (dec_d.kind == egdc_pkg::KIND_BYTE) begin
						ok     = 1'b1;
						ok_val = egdc_pkg::VALUE_BITS'(dec_d.acc[egdc_pkg::BYTE_BITS-1:0]);
					end else begin
						fin = 1'b1;
					end
				end else if (end_s1) begin
					fail    = 1'b1;
					fail_st = egdc_pkg::ST_TRUNC;
				end
			end
		end
		// end of a gamma code, of the length field of a delta code, or of a delta code's value bits
		if (fin) begin
			if (dec_d.kind == egdc_pkg::KIND_GAMMA || dec_d.delta_stage) begin
				ok     = 1'b1;
				ok_val = dec_d.acc;
			end else if (dec_d.acc == '0 ||
					dec_d.acc > egdc_pkg::VALUE_BITS'(egdc_pkg::VALUE_BITS)) begin
				fail = 1'b1;
			end else if (dec_d.acc == egdc_pkg::VALUE_BITS'(1)) begin
				ok     = 1'b1;
				ok_val = egdc_pkg::VALUE_BITS'(1);
			end else begin
				dec_d.delta_stage = 1'b1;
				dec_d.phase       = PH_BINARY;
				dec_d.bits_left   = dec_d.acc[egdc_pkg::LEN_W-1:0] - 6'd1;
				dec_d.acc         = egdc_pkg::VALUE_BITS'(1);
				if (end_s1) begin
					fail    = 1'b1;
					fail_st = egdc_pkg::ST_TRUNC;
				end
			end
		end
		if (fail) begin
			dec_d          = '0;
			dec_emit       = 1'b1;
			dec_res.status = fail_st;
		end else if (ok) begin
			dec_d                 = '0;
			dec_emit              = 1'b1;
			dec_res.decoded_value = ok_val;
			dec_res.status        = egdc_pkg::ST_DECODED;
		end
	end

	assign adv     = !out_v_s2 || out_ch.ready;
	assign s1_fire = s1_v && adv;
	assign in_ch.ready = !s1_v || adv;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign emit    = (dir_q == egdc_pkg::DIR_ENCODE) ? 1'b1 : dec_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= egdc_pkg::DIR_ENCODE;
			s1_v     <= 1'b0;
			out_v_s2 <= 1'b0;
			dec_q    <= '0;
		end else begin
			if (cfg_we) dir_q <= cfg_wdata;
			if (in_fire) s1_v <= 1'b1;
			else if (s1_fire) s1_v <= 1'b0;
			if (adv) out_v_s2 <= s1_fire && emit;
			if (s1_fire && dir_q == egdc_pkg::DIR_DECODE) dec_q <= dec_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1  <= in_ch.func;
			value_s1 <= in_ch.value;
			bit_s1   <= in_ch.coded_bit;
			end_s1   <= in_ch.stream_end;
		end
		if (s1_fire && emit) begin
			res_s2 <= (dir_q == egdc_pkg::DIR_ENCODE) ? enc_res : dec_res;
		end
	end

	assign out_ch.valid         = out_v_s2;
	assign out_ch.code_bits     = res_s2.code_bits;
	assign out_ch.code_length   = res_s2.code_length;
	assign out_ch.decoded_value = res_s2.decoded_value;
	assign out_ch.status        = res_s2.status;

endmodule

[rtl/core/egdc_checker.sv]
// Port-level checks of the codec top level, attached by bind.
// Depends on egdc_pkg and elias_gamma_delta_codec_unit_assert.svh.
`include "elias_gamma_delta_codec_unit_assert.svh"

module egdc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [egdc_pkg::CODE_W-1:0]     code_bits,
	input logic [egdc_pkg::LEN_W-1:0]      code_length,
	input logic [egdc_pkg::VALUE_BITS-1:0] decoded_value,
	input logic [egdc_pkg::STATUS_W-1:0]   status
);

	logic stalled;
	logic is_enc;
	logic is_other;
	logic [egdc_pkg::CODE_W+egdc_pkg::LEN_W+egdc_pkg::VALUE_BITS+egdc_pkg::STATUS_W-1:0] res_word;

	assign stalled  = out_valid && !out_ready;
	assign is_enc   = out_valid && status == egdc_pkg::ST_ENCODED;
	assign is_other = out_valid && status != egdc_pkg::ST_ENCODED;
	assign res_word = {code_bits, code_length, decoded_value, status};

	`EGDC_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(res_word))
	`EGDC_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`EGDC_ASSERT_IMPL(a_encoded_shape, clk, arst_n, is_enc, code_length != '0 && decoded_value == '0)
	`EGDC_ASSERT_IMPL(a_other_no_code, clk, arst_n, is_other, code_length == '0 && code_bits == '0)

endmodule

bind elias_gamma_delta_codec_unit egdc_checker u_egdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.code_bits     (out_ch.code_bits),
	.code_length   (out_ch.code_length),
	.decoded_value (out_ch.decoded_value),
	.status        (out_ch.status)
);

[dv/elias_gamma_delta_codec_unit_tb.sv]
// Self-checking testbench for elias_gamma_delta_codec_unit: gamma, delta and byte
// encode/decode predicted per transaction and compared field by field with each result.
// Depends on egdc_pkg, egdc_stream_if and the codec RTL.
`timescale 1ns / 1ps

module elias_gamma_delta_codec_unit_tb;
	import egdc_pkg::*;

	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 500000;

	typedef enum logic [1:0] {AWAIT_FIRST, IN_PREFIX, IN_BINARY} dec_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	egdc_in_if  item_ch();
	egdc_out_if res_ch();

	elias_gamma_delta_codec_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (item_ch),
		.out_ch   (res_ch)
	);

	always #2 clk = ~clk;

	result_t    results_due[$];
	int         errors = 0;
	int         cycle_count = 0;
	bit         src_burst = 1'b0;
	bit         snk_burst = 1'b0;
	bit         hold_req = 1'b0;

	logic       dir_model;
	dec_phase_t dec_phase;
	int         pre_cnt;
	logic [63:0] acc;
	int         left;
	logic [FUNC_W-1:0] dec_kind;
	bit         in_trail;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout, %0d results outstanding", $time, results_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int top_bit(input logic [63:0] x);
		int i;
		top_bit = 0;
		for (i = 0; i < 64; i++)
			if (x[i]) top_bit = i;
	endfunction

	function automatic void gamma_word(input logic [63:0] m, output logic [63:0] bits,
			output int len);
		int n;
		logic [63:0] low;
		n = top_bit(m);
		low = (64'd1 << n) - 64'd1;
		bits = (low << (n + 1)) | (m & low);
		len = 2 * n + 1;
	endfunction

	function automatic result_t encode_value(input logic [FUNC_W-1:0] kind,
			input logic [VALUE_BITS-1:0] v);
		result_t r;
		int n, glen;
		logic [63:0] g, low;
		r = '0;
		if (kind == KIND_BYTE) begin
			r.code_bits = {56'd0, v[7:0]};
			r.code_length = LEN_W'(BYTE_BITS);
		end else if (kind == KIND_BAD || v == '0) begin
			r.status = ST_INVALID;
		end else if (kind == KIND_GAMMA) begin
			gamma_word({33'd0, v}, g, glen);
			r.code_bits = g;
			r.code_length = LEN_W'(glen);
		end else begin
			n = top_bit({33'd0, v});
			gamma_word(64'(n + 1), g, glen);
			low = (64'd1 << n) - 64'd1;
			r.code_bits = (g << n) | ({33'd0, v} & low);
			r.code_length = LEN_W'(glen + n);
		end
		return r;
	endfunction

	function automatic void clear_decoder();
		dec_phase = AWAIT_FIRST;
		pre_cnt = 0;
		acc = '0;
		left = 0;
		dec_kind = KIND_GAMMA;
		in_trail = 1'b0;
	endfunction

	function automatic bit abort_code(input logic [STATUS_W-1:0] st, output result_t r);
		clear_decoder();
		r = '0;
		r.status = st;
		return 1'b1;
	endfunction

	function automatic bit close_gamma(input bit e, output result_t r);
		logic [63:0] m;
		r = '0;
		if (dec_kind == KIND_GAMMA || in_trail) begin
			r.decoded_value = acc[VALUE_BITS-1:0];
			r.status = ST_DECODED;
			clear_decoder();
			return 1'b1;
		end
		m = acc;
		if (m == 0 || m - 64'd1 >= VALUE_BITS) return abort_code(ST_INVALID, r);
		if (m == 64'd1) begin
			r.decoded_value = 1;
			r.status = ST_DECODED;
			clear_decoder();
			return 1'b1;
		end
		in_trail = 1'b1;
		dec_phase = IN_BINARY;
		left = int'(m - 64'd1);
		acc = 64'd1;
		if (e) return abort_code(ST_TRUNC, r);
		return 1'b0;
	endfunction

	function automatic bit decode_expect(input logic [FUNC_W-1:0] f, input bit b, input bit e,
			output result_t r);
		r = '0;
		if (dec_phase == AWAIT_FIRST) begin
			clear_decoder();
			dec_kind = f;
			if (f == KIND_BAD) return abort_code(ST_INVALID, r);
			if (f == KIND_BYTE) begin
				dec_phase = IN_BINARY;
				left = BYTE_BITS;
			end else begin
				dec_phase = IN_PREFIX;
			end
		end
		if (dec_phase == IN_PREFIX) begin
			if (b) begin
				pre_cnt++;
				if (pre_cnt >= VALUE_BITS) return abort_code(ST_INVALID, r);
				if (e) return abort_code(ST_TRUNC, r);
				return 1'b0;
			end
			acc = 64'd1;
			if (pre_cnt == 0) return close_gamma(e, r);
			dec_phase = IN_BINARY;
			left = pre_cnt;
			pre_cnt = 0;
			if (e) return abort_code(ST_TRUNC, r);
			return 1'b0;
		end
		acc = ((acc << 1) | 64'(b)) & 64'hFFFF_FFFF;
		if (left > 0) left--;
		if (left == 0) begin
			if (dec_kind == KIND_BYTE) begin
				r.decoded_value = VALUE_BITS'(acc[7:0]);
				r.status = ST_DECODED;
				clear_decoder();
				return 1'b1;
			end
			return close_gamma(e, r);
		end
		if (e) return abort_code(ST_TRUNC, r);
		return 1'b0;
	endfunction

	function automatic logic [VALUE_BITS-1:0] random_value();
		int lead;
		logic [VALUE_BITS-1:0] low;
		lead = $urandom_range(0, VALUE_BITS - 1);
		low = (VALUE_BITS'(1) << lead) - VALUE_BITS'(1);
		return (VALUE_BITS'(1) << lead) | (VALUE_BITS'($urandom) & low);
	endfunction

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [VALUE_BITS-1:0] v,
			input bit b, input bit e);
		int gap;
		result_t w;
		gap = src_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.func       <= f;
		item_ch.value      <= v;
		item_ch.coded_bit  <= b;
		item_ch.stream_end <= e;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (dir_model == DIR_DECODE) begin
			if (decode_expect(f, b, e, w)) results_due.push_back(w);
		end else begin
			results_due.push_back(encode_value(f, v));
		end
	endtask

	// bits hi down to lo, MSB first; stream end only on the last one sent
	task automatic send_code(input logic [FUNC_W-1:0] kind, input logic [63:0] bits,
			input int hi, input int lo, input bit e);
		int i;
		for (i = hi; i >= lo; i--)
			send_item(i == hi ? kind : FUNC_W'($urandom_range(0, 3)), VALUE_BITS'($urandom),
				bits[i], e && i == lo);
	endtask

	task automatic send_encoded(input logic [FUNC_W-1:0] kind, input logic [VALUE_BITS-1:0] v,
			input bit e);
		result_t w;
		w = encode_value(kind, v);
		send_code(kind, w.code_bits, int'(w.code_length) - 1, 0, e);
	endtask

	task automatic settle_block();
		item_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		dir_model = d;
	endtask

	task automatic test_encode_corners();
		write_direction(DIR_ENCODE);
		send_item(KIND_GAMMA, 1, 0, 0);
		send_item(KIND_GAMMA, 2, 1, 0);
		send_item(KIND_GAMMA, 3, 0, 1);
		send_item(KIND_GAMMA, '1, 1, 1);
		send_item(KIND_GAMMA, 0, 0, 0);
		send_item(KIND_DELTA, 1, 0, 0);
		send_item(KIND_DELTA, 2, 0, 0);
		send_item(KIND_DELTA, 4, 0, 0);
		send_item(KIND_DELTA, '1, 0, 0);
		send_item(KIND_DELTA, 0, 0, 0);
		send_item(KIND_BYTE, 0, 0, 0);
		send_item(KIND_BYTE, 8'hFF, 0, 0);
		send_item(KIND_BYTE, 31'h7FFF_FF5A, 0, 0);
		send_item(KIND_BAD, 5, 0, 0);
		send_item(KIND_BAD, 0, 0, 0);
	endtask

	task automatic test_decode_corners();
		result_t w;
		logic [63:0] g;
		int len;
		write_direction(DIR_DECODE);
		send_encoded(KIND_GAMMA, 1, 0);
		send_encoded(KIND_GAMMA, '1, 0);
		send_encoded(KIND_DELTA, 1, 0);
		send_encoded(KIND_DELTA, '1, 0);
		send_encoded(KIND_BYTE, 8'hA5, 0);
		send_encoded(KIND_BYTE, 0, 0);
		send_encoded(KIND_BYTE, 8'hFF, 1);
		send_code(KIND_BAD, 64'd0, 0, 0, 0);
		send_encoded(KIND_GAMMA, 5, 1);
		send_encoded(KIND_GAMMA, 1, 1);
		w = encode_value(KIND_GAMMA, 13);
		send_code(KIND_GAMMA, w.code_bits, int'(w.code_length) - 1, int'(w.code_length) - 2, 1);
		send_code(KIND_GAMMA, w.code_bits, int'(w.code_length) - 1, 1, 1);
		// stream ends right where the delta length field completes
		w = encode_value(KIND_DELTA, 2);
		send_code(KIND_DELTA, w.code_bits, 3, 1, 1);
		send_code(KIND_BYTE, 64'h3C, 7, 4, 1);
		// prefix overflow wins over stream end
		send_code(KIND_GAMMA, '1, VALUE_BITS - 1, 0, 1);
		send_code(KIND_DELTA, '1, VALUE_BITS - 1, 0, 0);
		gamma_word(64'd32, g, len);
		send_code(KIND_DELTA, g, len - 1, 0, 0);
		gamma_word(64'd63, g, len);
		send_code(KIND_DELTA, g, len - 1, 0, 1);
	endtask

	task automatic test_direction_switch();
		result_t w;
		int len;
		write_direction(DIR_DECODE);
		w = encode_value(KIND_DELTA, 31'h12345);
		len = int'(w.code_length);
		send_code(KIND_DELTA, w.code_bits, len - 1, len - 7, 0);
		write_direction(DIR_ENCODE);
		send_item(KIND_GAMMA, 9, 1, 1);
		send_item(KIND_DELTA, 300, 0, 1);
		send_item(KIND_BYTE, 7, 1, 0);
		send_item(KIND_BAD, 1, 0, 0);
		write_direction(DIR_DECODE);
		send_code(KIND_GAMMA, w.code_bits, len - 8, 0, 0);
		w = encode_value(KIND_GAMMA, 31'h2F1);
		len = int'(w.code_length);
		send_code(KIND_GAMMA, w.code_bits, len - 1, len - 14, 0);
		write_direction(DIR_ENCODE);
		send_item(KIND_GAMMA, 77, 0, 0);
		write_direction(DIR_DECODE);
		send_code(KIND_BYTE, w.code_bits, len - 15, 0, 0);
	endtask

	task automatic test_result_backpressure();
		write_direction(DIR_ENCODE);
		src_burst = 1'b1;
		hold_req = 1'b1;
		repeat (40) send_item(KIND_GAMMA, random_value(), 0, 0);
		src_burst = 1'b0;
	endtask

	task automatic test_random_encode();
		int pick;
		logic [FUNC_W-1:0] kind;
		logic [VALUE_BITS-1:0] v;
		write_direction(DIR_ENCODE);
		repeat (650) begin
			if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
			pick = $urandom_range(0, 19);
			kind = pick < 8 ? KIND_GAMMA : pick < 15 ? KIND_DELTA : pick < 19 ? KIND_BYTE : KIND_BAD;
			if ($urandom_range(0, 15) == 0) v = '0;
			else if ($urandom_range(0, 3) == 0) v = VALUE_BITS'($urandom);
			else v = random_value();
			send_item(kind, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		src_burst = 1'b0;
	endtask

	task automatic test_random_decode();
		int sent_bits, pick, len, stop;
		bit e;
		logic [FUNC_W-1:0] kind;
		logic [63:0] g;
		result_t w;
		write_direction(DIR_DECODE);
		sent_bits = 0;
		while (sent_bits < 850) begin
			if ($urandom_range(0, 15) == 0) src_burst = !src_burst;
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				repeat ($urandom_range(1, 4)) begin
					send_item(FUNC_W'($urandom_range(0, 3)), VALUE_BITS'($urandom),
						1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
					sent_bits++;
				end
				continue;
			end
			if (pick < 7) begin
				kind = KIND_GAMMA;
				g = '1;
				len = VALUE_BITS;
			end else if (pick < 10) begin
				kind = KIND_DELTA;
				gamma_word(64'($urandom_range(32, 63)), g, len);
			end else if (pick < 14) begin
				kind = KIND_BAD;
				g = 64'($urandom);
				len = 1;
			end else begin
				kind = pick < 50 ? KIND_GAMMA : pick < 82 ? KIND_DELTA : KIND_BYTE;
				w = encode_value(kind, kind == KIND_BYTE ? VALUE_BITS'($urandom) : random_value());
				g = w.code_bits;
				len = int'(w.code_length);
			end
			stop = len;
			e = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				stop = $urandom_range(1, len);
				e = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				e = 1'b1;
			end
			send_code(kind, g, len - 1, len - stop, e);
			sent_bits += stop;
		end
		src_burst = 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		int taken;
		result_t got, want;
		res_ch.ready <= 1'b0;
		taken = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = snk_burst ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			got = {res_ch.code_bits, res_ch.code_length, res_ch.decoded_value, res_ch.status};
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none, actual %h", $time, got);
			end else begin
				want = results_due.pop_front();
				if (got.code_bits !== want.code_bits) begin
					errors++;
					$display("%0t code_bits expected %h actual %h", $time,
						want.code_bits, got.code_bits);
				end
				if (got.code_length !== want.code_length) begin
					errors++;
					$display("%0t code_length expected %0d actual %0d", $time,
						want.code_length, got.code_length);
				end
				if (got.decoded_value !== want.decoded_value) begin
					errors++;
					$display("%0t decoded_value expected %h actual %h", $time,
						want.decoded_value, got.decoded_value);
				end
				if (got.status !== want.status) begin
					errors++;
					$display("%0t status expected %0d actual %0d", $time,
						want.status, got.status);
				end
			end
			taken++;
			if (taken % 40 == 0) snk_burst = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.func       <= KIND_GAMMA;
		item_ch.value      <= '0;
		item_ch.coded_bit  <= 1'b0;
		item_ch.stream_end <= 1'b0;
		clear_decoder();
		dir_model = DIR_ENCODE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_corners();
		test_decode_corners();
		test_direction_switch();
		test_result_backpressure();
		test_random_encode();
		test_random_decode();
		settle_block();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
